// File: sv/pewt_pkg.sv
// Package for the sliding-window peak event counter: widths, codes, shared types.
`timescale 1ns / 1ps
package pewt_pkg;

    localparam int TIME_W          = 11;
    localparam int HOUR_W          = 5;
    localparam int MINUTE_W        = 6;
    localparam int COUNT_W         = 11;
    localparam int STATUS_W        = 2;
    localparam int MinutesPerHour  = 60;
    localparam int WINDOW_DEPTH_DEF = 1024;
    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(20);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_PUSH,
        S_DONE
    } seq_state_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] window_count;
        logic [COUNT_W-1:0] peak_count;
        status_t            status;
    } result_t;

endpackage

// File: sv/pewt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pewt_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: sv/pewt_seq.sv
// Sequencer: window FIFO pointers, eviction loop over one subtractor, peak tracking.
`timescale 1ns / 1ps
module pewt_seq #(
    parameter int WINDOW_DEPTH = pewt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pewt_pkg::TIME_W-1:0]   in_time,
    input  logic                          in_first,
    input  logic [pewt_pkg::TIME_W-1:0]   window_minutes,
    input  logic                          out_free,
    output pewt_pkg::result_t             result
);
    import pewt_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    seq_state_t        state_reg, state_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic              first_reg, first_next;
    logic [PTR_W-1:0]  oldest_reg, oldest_next;
    logic [PTR_W-1:0]  newest_reg, newest_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    status_t           status_reg, status_next;
    logic              result_load;

    // RAM control
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;

    // shared subtract unit: t minus previous time or minus oldest entry
    logic [TIME_W-1:0] sub_operand;
    logic [TIME_W:0]   diff;
    logic              borrow;
    logic              evict;
    logic [CNT_W-1:0]  held_inc;

    logic [CNT_W+COUNT_W-1:0] held_wide;
    logic [CNT_W+COUNT_W-1:0] peak_wide;

    pewt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (newest_reg),
        .wr_data (t_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sub_operand = (state_reg == S_CHECK) ? prev_reg : rd_data;
    assign diff        = {1'b0, t_reg} - {1'b0, sub_operand};
    assign borrow      = diff[TIME_W];
    assign evict       = !borrow && (diff[TIME_W-1:0] > window_minutes);
    assign held_inc    = held_reg + ONE_CNT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            newest_reg <= '0;
            held_reg   <= '0;
            peak_reg   <= '0;
            prev_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            held_reg   <= held_next;
            peak_reg   <= peak_next;
            prev_reg   <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        first_reg  <= first_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        t_next      = t_reg;
        first_next  = first_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        held_next   = held_reg;
        peak_next   = peak_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = oldest_reg;
        in_ready    = 1'b0;
        result_load = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    t_next     = in_time;
                    first_next = in_first;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (first_reg) begin
                    oldest_next = '0;
                    newest_next = '0;
                    held_next   = '0;
                    peak_next   = '0;
                    prev_next   = '0;
                    state_next  = S_PUSH;
                end else if (borrow) begin
                    status_next = ST_ORDER;
                    state_next  = S_DONE;
                end else if (held_reg != '0) begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_CMP: begin
                // rd_data holds the oldest entry; fetch the next one while evicting
                if (evict) begin
                    oldest_next = next_slot(oldest_reg);
                    held_next   = held_reg - ONE_CNT;
                    if (held_reg != ONE_CNT) begin
                        rd_en   = 1'b1;
                        rd_addr = next_slot(oldest_reg);
                    end else begin
                        state_next = S_PUSH;
                    end
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                prev_next = t_reg;
                if (held_reg == FULL_CNT) begin
                    status_next = ST_FULL;
                end else begin
                    wr_en       = 1'b1;
                    newest_next = next_slot(newest_reg);
                    held_next   = held_inc;
                    if (held_inc > peak_reg) begin
                        peak_next = held_inc;
                    end
                    status_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    result_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // counts are masked to the output width
    assign held_wide           = {{COUNT_W{1'b0}}, held_reg};
    assign peak_wide           = {{COUNT_W{1'b0}}, peak_reg};
    assign result.load         = result_load;
    assign result.window_count = held_wide[COUNT_W-1:0];
    assign result.peak_count   = peak_wide[COUNT_W-1:0];
    assign result.status       = status_reg;

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= FULL_CNT)
        else $error("held count above window depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready while an item is in work");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (held_reg < FULL_CNT))
        else $error("write into a full window store");

    a_cmp_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (held_reg != '0))
        else $error("eviction compare on an empty window");

    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (peak_reg >= held_reg))
        else $error("peak below current window count");
endmodule

// File: sv/peak_events_in_time_window_top.sv
// Top level of the sliding-window peak event counter.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  s_hour[4:0], s_minute[5:0], s_first_of_list
//  m_*       out        m_valid / m_ready  m_window_count[10:0], m_peak_count[10:0],
//                                          m_status[1:0]
//  cfg_*     in         cfg_we             cfg_wdata[10:0] (window width k, reset 20)
//
//  Per item the sequencer steps S_CHECK, S_CMP (one compare per read of the single RAM
//  port, until an entry stays or none is left), S_PUSH, S_DONE, where the result is loaded.
//  An out-of-order item skips to S_DONE; a list start or an empty window skips S_CMP.
//  s_ready comes back the cycle after the load. The block takes one item at a time.
//  Reset (aresetn low, synchronous) empties the window, clears peak and previous time
//  and sets k to 20; the time RAM itself is not cleared and needs no clearing pass.
//  A result waits in the output register while the next transaction is taken; the
//  sequencer only stalls at its last step if that register is still occupied.
//
module peak_events_in_time_window_top #(
    parameter int WINDOW_DEPTH = pewt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pewt_pkg::HOUR_W-1:0]     s_hour,
    input  logic [pewt_pkg::MINUTE_W-1:0]   s_minute,
    input  logic                            s_first_of_list,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pewt_pkg::COUNT_W-1:0]    m_window_count,
    output logic [pewt_pkg::COUNT_W-1:0]    m_peak_count,
    output logic [pewt_pkg::STATUS_W-1:0]   m_status,

    input  logic                            cfg_we,
    input  logic [pewt_pkg::TIME_W-1:0]     cfg_wdata
);
    import pewt_pkg::*;

    logic [TIME_W-1:0]   window_minutes_reg;
    logic [TIME_W-1:0]   event_time;
    logic                out_free;
    result_t             result;

    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_window_count_reg;
    logic [COUNT_W-1:0]  m_peak_count_reg;
    status_t             m_status_reg;

    // window width register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_minutes_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            window_minutes_reg <= cfg_wdata;
        end
    end

    // minutes of the day; out-of-range hour/minute still fit in 11 bits
    assign event_time = TIME_W'(s_hour) * TIME_W'(MinutesPerHour) + TIME_W'(s_minute);

    pewt_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_time        (event_time),
        .in_first       (s_first_of_list),
        .window_minutes (window_minutes_reg),
        .out_free       (out_free),
        .result         (result)
    );

    // output register: free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            m_window_count_reg <= result.window_count;
            m_peak_count_reg   <= result.peak_count;
            m_status_reg       <= result.status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_count = m_window_count_reg;
    assign m_peak_count   = m_peak_count_reg;
    assign m_status       = m_status_reg;
endmodule
